FILE: design/rsn_pkg.sv
// ----------------------------------------------------------------------------
// rsn_pkg
// types, constants and small functions for the row softmax normalizer
// ----------------------------------------------------------------------------
package rsn_pkg;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_EXP_RD,
    ST_EXP_CALC,
    ST_RECIP,
    ST_OUT_RD,
    ST_OUT_MUL,
    ST_OUT_SEND
  } rsn_state_t;

  localparam int unsigned LOG2E_Q14 = 23638;

  function automatic logic [16:0] pow2_frac(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52772;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48392;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

FILE: design/rsn_recip.sv
// ----------------------------------------------------------------------------
// rsn_recip
// restoring divider, floor(2^32 / den), one quotient bit per cycle
// ----------------------------------------------------------------------------
module rsn_recip import rsn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [21:0] den,
  output logic        done,
  output logic [16:0] quot
);

  logic [5:0]  step;
  logic        busy;
  logic [22:0] rem;
  logic [32:0] q;
  logic [22:0] trial;
  logic        bit_in;

  // dividend 2^32: bit 32 set, all else zero
  assign bit_in = (step == 6'd32);
  assign trial  = {rem[21:0], bit_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 6'd32;
        rem  <= '0;
        q    <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          q   <= {q[31:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[31:0], 1'b0};
        end
        if (step == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 6'd1;
        end
      end
    end
  end

  assign quot = q[16:0];

endmodule

FILE: design/row_softmax_normalizer_unit.sv
// ----------------------------------------------------------------------------
// row_softmax_normalizer_unit
// row-wise fixed-point softmax with a shared sequencer
// ----------------------------------------------------------------------------
// Scores are taken while a row fills. The transfer that completes a row
// starts a pass: per entry, a store read, then one multiply and
// interpolation for the exponential; then the bit-serial reciprocal of the
// sum; then per probability a read, a multiply and a send, the send held
// by any output stall. The input is not ready during the pass.
module row_softmax_normalizer_unit import rsn_pkg::*; #(
  parameter int MAX_ROW_LENGTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // score
  input  logic        s_tuser,   // last_in_batch
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // probability
  output logic        m_tlast,   // last_in_row
  output logic        m_tuser    // batch_done
);

  localparam int AW = $clog2(MAX_ROW_LENGTH);
  localparam int CW = AW + 1;

  rsn_state_t state, state_next;

  logic [6:0]          row_length;
  logic signed [15:0]  score_mem [MAX_ROW_LENGTH];
  logic [15:0]         exp_mem [MAX_ROW_LENGTH];
  logic signed [15:0]  row_peak;
  logic [CW-1:0]       fill_count;
  logic [CW-1:0]       idx;
  logic [21:0]         exp_total;
  logic                batch_flag;
  logic signed [15:0]  score_rd;
  logic [15:0]         exp_rd;
  logic [16:0]         recip;
  logic [32:0]         prod;
  logic                div_start, div_done;
  logic [16:0]         div_q;

  // effective length
  logic [CW-1:0] eff_len;
  always_comb begin
    if (row_length == 7'd0) eff_len = CW'(1);
    else if (row_length > 7'(MAX_ROW_LENGTH)) eff_len = CW'(MAX_ROW_LENGTH);
    else eff_len = CW'(row_length);
  end

  logic in_xfer, row_end;
  logic [CW-1:0] fill_inc;
  assign s_tready = (state == ST_LOAD);
  assign in_xfer  = s_tvalid && s_tready;
  assign fill_inc = fill_count + CW'(1);
  assign row_end  = (fill_inc >= eff_len);

  // exponential datapath
  logic [16:0] diff;
  logic [15:0] x;
  logic [31:0] ymul;
  logic [17:0] y;
  logic [9:0]  n;
  logic [3:0]  h, l;
  logic [16:0] t0, t1, m;
  logic [21:0] dl;
  logic [16:0] e_sh;
  logic [15:0] e_val;
  always_comb begin
    diff = 17'(row_peak) - 17'(score_rd);
    x    = diff[16] ? 16'd0 : diff[15:0];
    ymul = 32'(x) * 32'(LOG2E_Q14);
    y    = ymul[31:14];
    n    = y[17:8];
    h    = y[7:4];
    l    = y[3:0];
    t0   = pow2_frac({1'b0, h});
    t1   = pow2_frac({1'b0, h} + 5'd1);
    dl   = 22'(t0 - t1) * 22'(l);
    m    = t0 - 17'(dl >> 4);
    e_sh = (n >= 10'd17) ? 17'd0 : (m >> n[4:0]);
    e_val = e_sh[16] ? 16'hFFFF : e_sh[15:0];
  end

  rsn_recip u_recip (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .den   (exp_total),
    .done  (div_done),
    .quot  (div_q)
  );

  logic last_out;
  assign last_out = (idx + CW'(1) == fill_count);

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ST_LOAD:     if (in_xfer && row_end) state_next = ST_EXP_RD;
      ST_EXP_RD:   state_next = ST_EXP_CALC;
      ST_EXP_CALC: begin
        if (idx + CW'(1) == fill_count) begin
          state_next = ST_RECIP;
          div_start  = 1'b1;
        end else begin
          state_next = ST_EXP_RD;
        end
      end
      ST_RECIP:    if (div_done) state_next = ST_OUT_RD;
      ST_OUT_RD:   state_next = ST_OUT_MUL;
      ST_OUT_MUL:  state_next = ST_OUT_SEND;
      ST_OUT_SEND: begin
        if (m_tready) state_next = last_out ? ST_LOAD : ST_OUT_RD;
      end
      default:     state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (in_xfer) score_mem[fill_count[AW-1:0]] <= s_tdata;
    if (state == ST_EXP_CALC) exp_mem[idx[AW-1:0]] <= e_val;
    score_rd <= score_mem[idx[AW-1:0]];
    exp_rd   <= exp_mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= 7'd64;
      row_peak   <= '0;
      fill_count <= '0;
      exp_total  <= '0;
      batch_flag <= 1'b0;
      idx        <= '0;
    end else begin
      if (cfg_we) row_length <= cfg_wdata;
      unique case (state)
        ST_LOAD: begin
          if (in_xfer) begin
            if (fill_count == '0 || $signed(s_tdata) > row_peak) row_peak <= s_tdata;
            batch_flag <= s_tuser | ((fill_count == '0) ? 1'b0 : batch_flag);
            fill_count <= fill_inc;
            idx        <= '0;
            exp_total  <= '0;
          end
        end
        ST_EXP_CALC: begin
          exp_total <= exp_total + 22'(e_val);
          idx       <= (idx + CW'(1) == fill_count) ? '0 : idx + CW'(1);
        end
        ST_RECIP: if (div_done) recip <= div_q;
        ST_OUT_MUL: prod <= 33'(exp_rd) * 33'(recip);
        ST_OUT_SEND: begin
          if (m_tready) begin
            if (last_out) begin
              fill_count <= '0;
              batch_flag <= 1'b0;
              idx        <= '0;
            end else begin
              idx <= idx + CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  logic [16:0] p;
  assign p        = prod[32:16];
  assign m_tvalid = (state == ST_OUT_SEND);
  assign m_tdata  = p[16] ? 16'hFFFF : p[15:0];
  assign m_tlast  = last_out;
  assign m_tuser  = last_out & batch_flag;

endmodule
